### design/pngs_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG stored-RGB encoder.
// No dependencies.
package pngs_pkg;

	localparam int unsigned DEF_MAX_WIDTH = 8192;
	localparam int unsigned DEF_MAX_HEIGHT = 8192;
	localparam int unsigned DEF_STORED_BLOCK_MAX = 65535;

	localparam int unsigned CFG_W = 14;
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	localparam logic [63:0] PNG_SIG = 64'h89504E470D0A1A0A;
	localparam logic [31:0] NAME_IHDR = 32'h49484452;
	localparam logic [31:0] NAME_IDAT = 32'h49444154;
	localparam logic [31:0] NAME_IEND = 32'h49454E44;
	localparam logic [31:0] IEND_CRC = 32'hAE426082;
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;

	localparam logic [5:0] HDR_LAST = 6'd42;
	localparam logic [5:0] TAIL_LAST = 6'd19;
	localparam logic [5:0] BLK_LAST = 6'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DGO,
		S_DIV,
		S_LEN,
		S_HDR,
		S_RAW,
		S_BLK,
		S_TAIL
	} state_t;

	typedef struct packed {
		logic crc_en;
		logic crc_init;
		logic adl_en;
		logic adl_init;
	} sum_ctl_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

### design/pngs_div.sv
// Restoring divider by a constant, one quotient bit per cycle.
// Depends on nothing.
module pngs_div #(
	parameter int unsigned DW = 30,
	parameter int unsigned DIVISOR = 65535
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          busy,
	output logic [DW-1:0] quot
);
	localparam int unsigned RW = $clog2(DIVISOR + 1);
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] d_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [RW:0]   trial;
	logic          qbit;

	assign trial = {r_q, d_q[DW-1]};
	assign qbit = (trial >= (RW+1)'(DIVISOR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(DW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= dividend;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= qbit ? RW'(trial - (RW+1)'(DIVISOR)) : RW'(trial);
			d_q <= {d_q[DW-2:0], qbit};
		end
	end

	assign busy = run_q;
	assign quot = d_q;

endmodule

### design/pngs_sum.sv
// Running CRC-32 and Adler-32 over the bytes whose enable bits are set, one byte per cycle while enabled.
// Depends on pngs_pkg.
module pngs_sum
	import pngs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sum_ctl_t    ctl,
	input  logic [7:0]  data,
	output logic [31:0] crc,
	output logic [31:0] adler
);
	logic [31:0] crc_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic [16:0] low_sum;
	logic [15:0] low_n;
	logic [16:0] high_sum;
	logic [15:0] high_n;

	always_comb begin
		low_sum = {1'b0, low_q} + {9'd0, data};
		low_n = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
		high_sum = {1'b0, high_q} + {1'b0, low_n};
		high_n = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ONES;
			low_q <= 16'd1;
			high_q <= 16'd0;
		end else begin
			if (ctl.crc_en) crc_q <= crc_byte(ctl.crc_init ? CRC_ONES : crc_q, data);
			if (ctl.adl_init) begin
				low_q <= 16'd1;
				high_q <= 16'd0;
			end else if (ctl.adl_en) begin
				low_q <= low_n;
				high_q <= high_n;
			end
		end
	end

	assign crc = crc_q;
	assign adler = {high_q, low_q};

endmodule

### design/png_stored_rgb_encoder.sv
// Top level: byte sequencer emitting a PNG file with stored deflate blocks.
// Depends on pngs_pkg, pngs_div, pngs_sum.
//
//  channel | signals                          | content
//  s_      | s_tvalid s_tready s_tdata s_tuser | tdata pixel_bgra, tuser mode
//  m_      | m_tvalid m_tready m_tdata m_tlast m_tuser | tdata out_byte, tlast item_last,
//          |                                  | tuser file_last
//  wr_     | wr_en wr_addr wr_data            | 0 image_width, 1 image_height
//
// One byte per cycle while m_tready holds; a pixel gives 3 bytes, or 4 with the row's
// filter byte, plus 5 per block header, a frame end 20 more. A start does size setup
// (bit-serial divide of the raw length) and then 43 header bytes. Input is taken only
// between items. Reset leaves no frame open and both sizes at 1.
module png_stored_rgb_encoder
	import pngs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned STORED_BLOCK_MAX = DEF_STORED_BLOCK_MAX
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // pixel_bgra
	input  logic             s_tuser,   // mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,
	output logic             m_tuser,   // file_last
	input  logic             wr_en,
	input  logic             wr_addr,
	input  logic [CFG_W-1:0] wr_data
);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam longint RAW_MAX = longint'(MAX_HEIGHT) * (64'd1 + 64'd3 * longint'(MAX_WIDTH));
	localparam int unsigned RAW_W = $clog2(RAW_MAX + 1);
	localparam int unsigned DW = RAW_W + 1;

	state_t state_q, state_d;
	logic [5:0]       idx_q, idx_d;
	logic [CFG_W-1:0] width_q, height_q;
	logic [WW-1:0]    fw_q, col_q, fw_c;
	logic [HW-1:0]    fh_q, row_q, fh_c;
	logic             active_q, end_q, hdr_done_q;
	logic [31:0]      sr_q;
	logic [1:0]       cnt_q;
	logic [RAW_W-1:0] raw_q, raw_left_q;
	logic [31:0]      len_q;
	logic [15:0]      blk_left_q;
	logic [7:0]       od_q;
	logic             ov_q, ol_q, of_q;

	logic        emit_ok, emit, last_c, file_c, accept;
	logic [7:0]  byte_c;
	sum_ctl_t    ctl;
	logic [31:0] crc, adler, crcx;
	logic        div_busy;
	logic [DW-1:0] quot;
	logic [343:0] hdr_be;
	logic [159:0] tail_be;
	logic [39:0]  blk_be;
	logic [15:0]  chunk;
	logic         blk_final;

	pngs_div #(.DW(DW), .DIVISOR(STORED_BLOCK_MAX)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_DGO),
		.dividend(DW'(raw_q) + DW'(STORED_BLOCK_MAX - 1)),
		.busy(div_busy), .quot(quot)
	);

	pngs_sum u_sum (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .data(byte_c), .crc(crc), .adler(adler)
	);

	always_comb begin
		if (width_q == '0) fw_c = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) fw_c = WW'(MAX_WIDTH);
		else fw_c = WW'(width_q);
		if (height_q == '0) fh_c = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) fh_c = HW'(MAX_HEIGHT);
		else fh_c = HW'(height_q);
	end

	assign crcx = crc ^ CRC_ONES;
	assign hdr_be = {PNG_SIG, 32'd13, NAME_IHDR, 32'(fw_q), 32'(fh_q), 8'd8, 8'd2, 24'd0,
		crcx, len_q, NAME_IDAT, ZLIB_CMF, ZLIB_FLG};
	assign tail_be = {adler, crcx, 32'd0, NAME_IEND, IEND_CRC};
	assign chunk = (64'(raw_left_q) < 64'(STORED_BLOCK_MAX)) ? 16'(raw_left_q)
		: 16'(STORED_BLOCK_MAX);
	assign blk_final = (64'(raw_left_q) <= 64'(STORED_BLOCK_MAX));
	assign blk_be = {7'd0, blk_final, chunk[7:0], chunk[15:8], ~chunk[7:0], ~chunk[15:8]};

	assign emit_ok = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		byte_c = 8'd0;
		last_c = 1'b0;
		file_c = 1'b0;
		emit = 1'b0;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && !s_tuser) begin
					ctl.adl_init = 1'b1;
					state_d = S_MUL;
				end else if (s_tvalid && active_q) begin
					state_d = S_RAW;
				end
			end
			S_MUL: state_d = S_DGO;
			S_DGO: state_d = S_DIV;
			S_DIV: if (!div_busy) state_d = S_LEN;
			S_LEN: begin
				state_d = S_HDR;
				idx_d = '0;
			end
			S_HDR: begin
				byte_c = hdr_be[9'(343 - 8 * int'(idx_q)) -: 8];
				if (emit_ok) begin
					emit = 1'b1;
					ctl.crc_en = (idx_q >= 6'd12 && idx_q <= 6'd28) || (idx_q >= 6'd37);
					ctl.crc_init = (idx_q == 6'd12) || (idx_q == 6'd37);
					if (idx_q == HDR_LAST) begin
						last_c = 1'b1;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			S_RAW: begin
				byte_c = sr_q[31:24];
				if (blk_left_q == '0 && !hdr_done_q) begin
					state_d = S_BLK;
					idx_d = '0;
				end else if (emit_ok) begin
					emit = 1'b1;
					ctl.crc_en = 1'b1;
					ctl.adl_en = 1'b1;
					if (cnt_q == '0) begin
						if (end_q) begin
							state_d = S_TAIL;
							idx_d = '0;
						end else begin
							last_c = 1'b1;
							state_d = S_IDLE;
						end
					end
				end
			end
			S_BLK: begin
				byte_c = blk_be[6'(39 - 8 * int'(idx_q)) -: 8];
				if (emit_ok) begin
					emit = 1'b1;
					ctl.crc_en = 1'b1;
					if (idx_q == BLK_LAST) state_d = S_RAW;
					else idx_d = idx_q + 1'b1;
				end
			end
			S_TAIL: begin
				byte_c = tail_be[8'(159 - 8 * int'(idx_q)) -: 8];
				if (emit_ok) begin
					emit = 1'b1;
					ctl.crc_en = (idx_q < 6'd4);
					if (idx_q == TAIL_LAST) begin
						last_c = 1'b1;
						file_c = 1'b1;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			ov_q <= 1'b0;
			active_q <= 1'b0;
			width_q <= CFG_W'(1);
			height_q <= CFG_W'(1);
			fw_q <= WW'(1);
			fh_q <= HW'(1);
			col_q <= '0;
			row_q <= '0;
			end_q <= 1'b0;
			hdr_done_q <= 1'b0;
			cnt_q <= '0;
			blk_left_q <= '0;
			raw_left_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (wr_en && wr_addr == REG_IMAGE_WIDTH) width_q <= wr_data;
			if (wr_en && wr_addr == REG_IMAGE_HEIGHT) height_q <= wr_data;
			if (emit) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;

			if (accept && !s_tuser) begin
				fw_q <= fw_c;
				fh_q <= fh_c;
				col_q <= '0;
				row_q <= '0;
				blk_left_q <= '0;
				hdr_done_q <= 1'b0;
				active_q <= 1'b1;
			end else if (accept && active_q) begin
				cnt_q <= (col_q == '0) ? 2'd3 : 2'd2;
				if ((col_q + 1'b1) >= fw_q) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
					end_q <= (row_q + 1'b1) >= fh_q;
					if ((row_q + 1'b1) >= fh_q) active_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
					end_q <= 1'b0;
				end
			end

			if (state_q == S_LEN) raw_left_q <= raw_q;
			if (state_q == S_BLK && emit && idx_q == BLK_LAST) begin
				blk_left_q <= chunk;
				hdr_done_q <= 1'b1;
			end
			if (state_q == S_RAW && emit) begin
				hdr_done_q <= 1'b0;
				if (blk_left_q != '0) blk_left_q <= blk_left_q - 1'b1;
				if (raw_left_q != '0) raw_left_q <= raw_left_q - 1'b1;
				if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			od_q <= byte_c;
			ol_q <= last_c;
			of_q <= file_c;
		end
		if (accept && s_tuser) begin
			sr_q <= (col_q == '0) ? {8'd0, s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]}
				: {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0], 8'd0};
		end else if (state_q == S_RAW && emit) begin
			sr_q <= {sr_q[23:0], 8'd0};
		end
		if (state_q == S_MUL) begin
			raw_q <= RAW_W'(RAW_W'(fh_q) * (RAW_W'(fw_q) + RAW_W'(fw_q) + RAW_W'(fw_q)
				+ RAW_W'(1)));
		end
		if (state_q == S_LEN) begin
			len_q <= 32'(64'(raw_q) + (64'(quot) << 2) + 64'(quot) + 64'd6);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = od_q;
	assign m_tlast = ol_q;
	assign m_tuser = of_q;

endmodule

### tb/sv/png_stored_rgb_encoder_tb.sv
// Self-checking testbench for png_stored_rgb_encoder: predicts every PNG file byte per request
// and compares the output stream in order. Depends on pngs_pkg and the encoder RTL.
module png_stored_rgb_encoder_tb;
	import pngs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAXW = 8192;
	localparam int unsigned MAXH = 8192;
	localparam int unsigned BLKMAX = 65535;
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct {
		logic mode;
		logic [31:0] bgra;
	} pix_req_t;

	typedef struct {
		logic [7:0] data;
		logic item_end;
		logic file_end;
	} file_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic wr_en = 1'b0;
	logic wr_addr = 1'b0;
	logic [CFG_W-1:0] wr_data = '0;

	png_stored_rgb_encoder dut (.*);

	pix_req_t req_q[$];
	file_byte_t png_q[$];
	int errors = 0;
	int unsigned cyc = 0;
	bit req_fire = 0;

	// encoder shadow state
	logic [13:0] reg_w = 14'd1, reg_h = 14'd1;
	bit in_frame = 0;
	logic [31:0] idat_crc = 32'hFFFFFFFF;
	int unsigned ad_lo = 1, ad_hi = 0;
	int unsigned col = 0, row = 0, fw = 1, fh = 1, blk_left = 0;
	longint unsigned raw_left = 0;

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		file_byte_t e;
		e.data = b;
		e.item_end = 1'b0;
		e.file_end = 1'b0;
		png_q.insert(png_q.size(), e);
	endfunction

	function automatic void put_word(logic [31:0] v);
		for (int i = 3; i >= 0; i--) put_byte(v[i*8 +: 8]);
	endfunction

	function automatic logic [31:0] put_name(logic [31:0] c, logic [31:0] nm);
		for (int i = 3; i >= 0; i--) begin
			c = crc_step(c, nm[i*8 +: 8]);
			put_byte(nm[i*8 +: 8]);
		end
		return c;
	endfunction

	function automatic void put_idat(logic [7:0] b);
		idat_crc = crc_step(idat_crc, b);
		put_byte(b);
	endfunction

	function automatic void put_payload(logic [7:0] b);
		int unsigned len;
		if (blk_left == 0) begin
			len = (raw_left < BLKMAX) ? int'(raw_left) : BLKMAX;
			put_idat((raw_left <= BLKMAX) ? 8'd1 : 8'd0);
			put_idat(len[7:0]);
			put_idat(len[15:8]);
			put_idat(~len[7:0]);
			put_idat(~len[15:8]);
			blk_left = len;
		end
		ad_lo = (ad_lo + b) % 65521;
		ad_hi = (ad_hi + ad_lo) % 65521;
		put_idat(b);
		if (blk_left > 0) blk_left--;
		if (raw_left > 0) raw_left--;
	endfunction

	function automatic int unsigned fit_size(int unsigned v, int unsigned lim);
		return (v == 0) ? 1 : ((v > lim) ? lim : v);
	endfunction

	function automatic void predict_request(logic mode, logic [31:0] px);
		int unsigned n0;
		logic [31:0] c;
		logic [103:0] ihdr;
		longint unsigned raw, blocks;
		n0 = png_q.size();
		if (mode == MODE_START) begin
			fw = fit_size(reg_w, MAXW);
			fh = fit_size(reg_h, MAXH);
			raw = longint'(fh) * (1 + 3 * longint'(fw));
			blocks = (raw + BLKMAX - 1) / BLKMAX;
			for (int i = 7; i >= 0; i--) put_byte(PNG_SIG[i*8 +: 8]);
			put_word(32'd13);
			c = put_name(32'hFFFFFFFF, NAME_IHDR);
			ihdr = {fw[31:0], fh[31:0], 8'd8, 8'd2, 24'd0};
			for (int i = 12; i >= 0; i--) begin
				c = crc_step(c, ihdr[i*8 +: 8]);
				put_byte(ihdr[i*8 +: 8]);
			end
			put_word(~c);
			put_word(32'(raw + 5 * blocks + 6));
			idat_crc = put_name(32'hFFFFFFFF, NAME_IDAT);
			put_idat(8'h78);
			put_idat(8'h01);
			ad_lo = 1;
			ad_hi = 0;
			col = 0;
			row = 0;
			blk_left = 0;
			raw_left = raw;
			in_frame = 1;
		end else if (in_frame) begin
			if (col == 0) put_payload(8'd0);
			put_payload(px[23:16]);
			put_payload(px[15:8]);
			put_payload(px[7:0]);
			col++;
			if (col >= fw) begin
				col = 0;
				row++;
				if (row >= fh) begin
					c = {ad_hi[15:0], ad_lo[15:0]};
					for (int i = 3; i >= 0; i--) put_idat(c[i*8 +: 8]);
					put_word(~idat_crc);
					put_word(32'd0);
					c = put_name(32'hFFFFFFFF, NAME_IEND);
					put_word(~c);
					in_frame = 0;
					png_q[png_q.size()-1].file_end = 1'b1;
				end
			end
		end
		if (png_q.size() > n0) png_q[png_q.size()-1].item_end = 1'b1;
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// calm window: no idling on either side
	function automatic bit go_now();
		return (cyc % 5000) < 1200 || $urandom_range(99) >= 37;
	endfunction

	always @(posedge clk) begin
		file_byte_t e;
		cyc <= cyc + 1;
		req_fire = s_tvalid && s_tready;
		if (req_fire) predict_request(s_tuser, s_tdata);
		if (m_tvalid && m_tready) begin
			if (png_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte %h last %b file_last %b", $time, m_tdata,
					m_tlast, m_tuser);
			end else begin
				e = png_q.pop_front();
				if (m_tdata !== e.data || m_tlast !== e.item_end || m_tuser !== e.file_end) begin
					errors++;
					$display("%0t: expected %h/%b/%b, got %h/%b/%b", $time, e.data, e.item_end,
						e.file_end, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (req_fire) void'(req_q.pop_front());
		m_tready <= go_now();
		if (arst_n && req_q.size() > 0 && (s_tvalid && !req_fire || go_now())) begin
			s_tvalid <= 1'b1;
			s_tuser <= req_q[0].mode;
			s_tdata <= req_q[0].bgra;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	task automatic send(logic mode, logic [31:0] px);
		pix_req_t r;
		r.mode = mode;
		r.bgra = px;
		req_q.insert(req_q.size(), r);
	endtask

	task automatic drain();
		while (req_q.size() > 0 || s_tvalid || png_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		drain();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_addr <= REG_IMAGE_WIDTH;
		wr_data <= w[CFG_W-1:0];
		reg_w = w[13:0];
		@(negedge clk);
		wr_addr <= REG_IMAGE_HEIGHT;
		wr_data <= h[CFG_W-1:0];
		reg_h = h[13:0];
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic full_frame(int unsigned npix);
		send(MODE_START, $urandom);
		repeat (npix) send(MODE_PIXEL, $urandom);
	endtask

	initial begin
		int unsigned w, h, sent, part;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// reset sizes, pixels outside a frame
		send(MODE_PIXEL, 32'hFFFFFFFF);
		send(MODE_START, 32'h0);
		send(MODE_PIXEL, 32'hFFFFFFFF);
		send(MODE_PIXEL, 32'h0);
		set_size(0, 0);
		send(MODE_START, 32'hFFFFFFFF);
		send(MODE_PIXEL, 32'h0);
		// sizes above the maximum, start during an open frame
		set_size(16383, 16383);
		send(MODE_START, 32'h0);
		send(MODE_START, 32'h0);
		set_size(8192, 8192);
		send(MODE_START, 32'h0);
		set_size(3, 2);
		send(MODE_START, 32'h0);
		send(MODE_PIXEL, 32'h00FF00FF);
		send(MODE_PIXEL, 32'hFF00FF00);
		full_frame(6);
		sent = 19;
		while (sent < 120) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
			h = $urandom_range(1, 3);
			set_size(w, h);
			if ($urandom_range(5) == 0) begin
				send(MODE_PIXEL, $urandom);
				sent++;
			end
			if ($urandom_range(6) == 0) begin
				part = $urandom_range(3);
				send(MODE_START, $urandom);
				repeat (part) send(MODE_PIXEL, $urandom);
				sent += part + 1;
			end
			full_frame(w * h);
			sent += w * h + 1;
		end
		drain();
		if (errors == 0 && png_q.size() == 0) begin
			$display("png_stored_rgb_encoder: match");
		end else begin
			$display("png_stored_rgb_encoder: mismatch");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("png_stored_rgb_encoder: mismatch");
		$finish;
	end

endmodule

### sim.f
design/pngs_pkg.sv
design/pngs_div.sv
design/pngs_sum.sv
design/png_stored_rgb_encoder.sv
tb/sv/png_stored_rgb_encoder_tb.sv
